[src/sorted_priority_task_queue_macros.svh]
// Assertion macros used by the sorted priority task queue datapath.
`ifndef SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define SPTQ_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("sptq: invariant violated");
// The antecedent implies the consequent in the same cycle.
`define SPTQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sptq: implication violated");
// The antecedent implies the consequent in the next cycle.
`define SPTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sptq: next-cycle check violated");
`else
`define SPTQ_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define SPTQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define SPTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/sptq_pkg.sv]
// Types and constants shared by the sorted priority task queue modules.
`timescale 1ns / 1ps
package sptq_pkg;
	localparam int OP_W     = 2;
	localparam int ID_W     = 16;
	localparam int PRI_W    = 8;
	localparam int TIME_W   = 16;
	localparam int STATUS_W = 3;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;
	localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RECORD   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic scan;
		logic apply;
		logic stream;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic go_stream;
		logic stream_last;
	} sts_t;
endpackage

[src/sptq_ctrl.sv]
// Controller state machine of the sorted priority task queue.
`timescale 1ns / 1ps
module sptq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sptq_pkg::sts_t sts,
	output sptq_pkg::cmd_t cmd,
	output logic          busy
);
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_APPLY  = 4'b0100,
		S_STREAM = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = sts.go_stream ? S_STREAM : S_IDLE;
			end
			S_STREAM: begin
				cmd.stream = 1'b1;
				if (sts.stream_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

[src/sptq_datapath.sv]
// Datapath of the sorted priority task queue: slot array, compare vectors, result register.
`timescale 1ns / 1ps
`include "sorted_priority_task_queue_macros.svh"
module sptq_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sptq_pkg::cmd_t                 cmd,
	output sptq_pkg::sts_t                 sts,
	input  logic [sptq_pkg::OP_W-1:0]      operation,
	input  logic [sptq_pkg::ID_W-1:0]      task_id,
	input  logic [sptq_pkg::PRI_W-1:0]     task_priority,
	input  logic [sptq_pkg::TIME_W-1:0]    run_time,
	output logic                           valid,
	output logic [sptq_pkg::STATUS_W-1:0]  status,
	output logic [sptq_pkg::ID_W-1:0]      out_id,
	output logic [sptq_pkg::PRI_W-1:0]     out_priority,
	output logic [sptq_pkg::TIME_W-1:0]    out_time,
	output logic                           last
);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [sptq_pkg::ID_W-1:0]   slot_id_q   [CAPACITY];
	logic [sptq_pkg::PRI_W-1:0]  slot_pri_q  [CAPACITY];
	logic [sptq_pkg::TIME_W-1:0] slot_time_q [CAPACITY];
	logic [sptq_pkg::ID_W-1:0]   slot_id_d   [CAPACITY];
	logic [sptq_pkg::PRI_W-1:0]  slot_pri_d  [CAPACITY];
	logic [sptq_pkg::TIME_W-1:0] slot_time_d [CAPACITY];

	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;

	logic [sptq_pkg::OP_W-1:0]   req_op_q;
	logic [sptq_pkg::ID_W-1:0]   req_id_q;
	logic [sptq_pkg::PRI_W-1:0]  req_pri_q;
	logic [sptq_pkg::TIME_W-1:0] req_time_q;

	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] tail;
	logic [CAPACITY-1:0] ge_d, ge_q;
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] hit_q;
	logic [CAPACITY-1:0] ins_at;
	logic [CAPACITY-1:0] rm_shift;

	logic [sptq_pkg::ID_W-1:0]   rec_id;
	logic [sptq_pkg::PRI_W-1:0]  rec_pri;
	logic [sptq_pkg::TIME_W-1:0] rec_time;

	logic full, found, is_stream_op, list_empty;

	logic                          valid_q, last_q;
	logic [sptq_pkg::STATUS_W-1:0] status_q;
	logic [sptq_pkg::ID_W-1:0]     out_id_q;
	logic [sptq_pkg::PRI_W-1:0]    out_pri_q;
	logic [sptq_pkg::TIME_W-1:0]   out_time_q;

	// Occupancy, compare and match vectors, one lane per slot.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ[i]   = (CW'(i) < count_q);
			ge_d[i]  = occ[i] && (slot_pri_q[i] >= req_pri_q);
			match[i] = occ[i] && (slot_id_q[i] == req_id_q);
		end
	end

	assign tail     = occ & ~(occ >> 1);
	assign ins_at   = ~ge_q & {ge_q[CAPACITY-2:0], 1'b1};
	assign rm_shift = ~(hit_q - CAPACITY'(1));

	// One-hot selection of the first matching task.
	always_comb begin
		rec_id   = '0;
		rec_pri  = '0;
		rec_time = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rec_id   = rec_id   | ({sptq_pkg::ID_W{hit_q[i]}}   & slot_id_q[i]);
			rec_pri  = rec_pri  | ({sptq_pkg::PRI_W{hit_q[i]}}  & slot_pri_q[i]);
			rec_time = rec_time | ({sptq_pkg::TIME_W{hit_q[i]}} & slot_time_q[i]);
		end
	end

	assign full         = (count_q == CW'(CAPACITY));
	assign found        = |hit_q;
	assign list_empty   = (count_q == '0);
	assign is_stream_op = (req_op_q == sptq_pkg::OP_DRAIN) || (req_op_q == sptq_pkg::OP_LIST);

	assign sts.go_stream   = is_stream_op && !list_empty;
	assign sts.stream_last = (rem_q == CW'(1));

	// Next slot contents: sorted insert, removal, drain shift or list rotation.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			slot_id_d[i]   = slot_id_q[i];
			slot_pri_d[i]  = slot_pri_q[i];
			slot_time_d[i] = slot_time_q[i];
		end
		if (cmd.apply && (req_op_q == sptq_pkg::OP_INSERT) && !full) begin
			for (int i = 1; i < CAPACITY; i++) begin
				if (!ge_q[i]) begin
					slot_id_d[i]   = slot_id_q[i-1];
					slot_pri_d[i]  = slot_pri_q[i-1];
					slot_time_d[i] = slot_time_q[i-1];
				end
			end
			for (int i = 0; i < CAPACITY; i++) begin
				if (ins_at[i]) begin
					slot_id_d[i]   = req_id_q;
					slot_pri_d[i]  = req_pri_q;
					slot_time_d[i] = req_time_q;
				end
			end
		end else if (cmd.apply && (req_op_q == sptq_pkg::OP_REMOVE) && found) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (rm_shift[i]) begin
					slot_id_d[i]   = slot_id_q[i+1];
					slot_pri_d[i]  = slot_pri_q[i+1];
					slot_time_d[i] = slot_time_q[i+1];
				end
			end
		end else if (cmd.stream && (req_op_q == sptq_pkg::OP_DRAIN)) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				slot_id_d[i]   = slot_id_q[i+1];
				slot_pri_d[i]  = slot_pri_q[i+1];
				slot_time_d[i] = slot_time_q[i+1];
			end
		end else if (cmd.stream) begin
			// List rotates the occupied slots so the order is back after a full pass.
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (tail[i]) begin
					slot_id_d[i]   = slot_id_q[0];
					slot_pri_d[i]  = slot_pri_q[0];
					slot_time_d[i] = slot_time_q[0];
				end else if (occ[i+1]) begin
					slot_id_d[i]   = slot_id_q[i+1];
					slot_pri_d[i]  = slot_pri_q[i+1];
					slot_time_d[i] = slot_time_q[i+1];
				end
			end
			if (tail[CAPACITY-1]) begin
				slot_id_d[CAPACITY-1]   = slot_id_q[0];
				slot_pri_d[CAPACITY-1]  = slot_pri_q[0];
				slot_time_d[CAPACITY-1] = slot_time_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			slot_id_q[i]   <= slot_id_d[i];
			slot_pri_q[i]  <= slot_pri_d[i];
			slot_time_q[i] <= slot_time_d[i];
		end
		if (cmd.latch) begin
			req_op_q   <= operation;
			req_id_q   <= task_id;
			req_pri_q  <= task_priority;
			req_time_q <= run_time;
		end
		if (cmd.scan) begin
			ge_q  <= ge_d;
			hit_q <= match & (~match + CAPACITY'(1));
		end
	end

	// Result register and payload.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			last_q <= 1'b1;
			case (req_op_q)
				sptq_pkg::OP_INSERT: begin
					status_q   <= full ? sptq_pkg::ST_DROPPED : sptq_pkg::ST_INSERTED;
					out_id_q   <= req_id_q;
					out_pri_q  <= req_pri_q;
					out_time_q <= req_time_q;
				end
				sptq_pkg::OP_REMOVE: begin
					status_q   <= found ? sptq_pkg::ST_REMOVED : sptq_pkg::ST_NOTFOUND;
					out_id_q   <= found ? rec_id : req_id_q;
					out_pri_q  <= rec_pri;
					out_time_q <= rec_time;
				end
				default: begin
					status_q   <= sptq_pkg::ST_EMPTY;
					out_id_q   <= '0;
					out_pri_q  <= '0;
					out_time_q <= '0;
				end
			endcase
		end else if (cmd.stream) begin
			status_q   <= sptq_pkg::ST_RECORD;
			out_id_q   <= slot_id_q[0];
			out_pri_q  <= slot_pri_q[0];
			out_time_q <= slot_time_q[0];
			last_q     <= sts.stream_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= (cmd.apply && !sts.go_stream) || cmd.stream;
			if (cmd.apply) begin
				rem_q <= count_q;
				if ((req_op_q == sptq_pkg::OP_INSERT) && !full) begin
					count_q <= count_q + CW'(1);
				end else if ((req_op_q == sptq_pkg::OP_REMOVE) && found) begin
					count_q <= count_q - CW'(1);
				end
			end else if (cmd.stream) begin
				rem_q <= rem_q - CW'(1);
				if (sts.stream_last && (req_op_q == sptq_pkg::OP_DRAIN)) begin
					count_q <= '0;
				end
			end
		end
	end

	assign valid        = valid_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pri_q;
	assign out_time     = out_time_q;
	assign last         = last_q;

	`SPTQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))
	`SPTQ_ASSERT_IMPLY(a_partial_is_record, clk, arst_n, valid_q && !last_q, status_q == sptq_pkg::ST_RECORD)
	`SPTQ_ASSERT_NEXT(a_gap_after_last, clk, arst_n, valid_q && last_q, !valid_q)
	`SPTQ_ASSERT_IMPLY(a_stream_nonempty, clk, arst_n, cmd.stream, rem_q != '0)
endmodule

[src/sorted_priority_task_queue.sv]
// Top level of the sorted priority task queue: controller plus datapath.
`timescale 1ns / 1ps
// Sorted priority task queue. Holds up to CAPACITY tasks in descending
// priority order; tasks of equal priority keep their arrival order. A request
// beat is taken on a rising edge where start is high and busy is low. Insert
// and remove produce exactly one result beat; drain and list produce one
// record beat per stored task (or one list-empty beat), with last set on the
// final one. Each result beat is shown for a single cycle with valid high and
// cannot be stalled, so the receiver must take every beat as it comes. Every
// request first runs a parallel compare of all slots (priority for insert,
// id for remove), whose vectors are registered, then shifts the slot row and
// loads the result register. An insert or remove shows its result in the
// same cycle that busy falls, so the next request can be taken only after
// that. A drain or list streams one record per cycle from the head slot;
// list rotates the occupied slots through a full turn so the stored order is
// unchanged at the end. No clearing pass is needed after reset: the task
// count starts at zero and slots beyond it are never read.
module sorted_priority_task_queue #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sptq_pkg::OP_W-1:0]     operation,
	input  logic [sptq_pkg::ID_W-1:0]     task_id,
	input  logic [sptq_pkg::PRI_W-1:0]    task_priority,
	input  logic [sptq_pkg::TIME_W-1:0]   run_time,
	output logic                          valid,
	output logic [sptq_pkg::STATUS_W-1:0] status,
	output logic [sptq_pkg::ID_W-1:0]     out_id,
	output logic [sptq_pkg::PRI_W-1:0]    out_priority,
	output logic [sptq_pkg::TIME_W-1:0]   out_time,
	output logic                          last
);
	sptq_pkg::cmd_t cmd;
	sptq_pkg::sts_t sts;

	// The controller sequences compare, apply and stream steps.
	sptq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the sorted slot row and the result register.
	sptq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.task_id       (task_id),
		.task_priority (task_priority),
		.run_time      (run_time),
		.valid         (valid),
		.status        (status),
		.out_id        (out_id),
		.out_priority  (out_priority),
		.out_time      (out_time),
		.last          (last)
	);
endmodule
